[src/tfs_pkg.sv]
// Shared types and constants for the terrain foothold selector.
package tfs_pkg;

	localparam logic [1:0] MODE_TREAD = 2'd0;
	localparam logic [1:0] MODE_FOOTPRINT = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [2:0] CFG_GROUND = 3'd0;
	localparam logic [2:0] CFG_MAX_STEP = 3'd1;
	localparam logic [2:0] CFG_MARGIN_X = 3'd2;
	localparam logic [2:0] CFG_MARGIN_Y = 3'd3;
	localparam logic [2:0] CFG_REGION_COUNT = 3'd4;

	localparam logic signed [25:0] STEP_BONUS = 26'sd614;
	localparam logic signed [25:0] CONTAIN_SLACK = 26'sd205;
	localparam logic signed [25:0] STEP_EPS = 26'sd4;

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [22:0]        hx;
		logic [22:0]        hy;
		logic signed [15:0] c;
		logic signed [15:0] s;
		logic signed [23:0] h;
	} tread_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FP_ROT,
		ST_FP_CHK,
		ST_RD,
		ST_ROT,
		ST_LOC,
		ST_BACK,
		ST_WORLD,
		ST_DIST,
		ST_SQRT,
		ST_CMP,
		ST_FB_ROT,
		ST_FB_CHK,
		ST_DONE
	} state_t;

	// floor((v + 8192) / 16384) as an arithmetic shift
	function automatic logic signed [26:0] rq14(input logic signed [41:0] v);
		logic signed [41:0] t;
		t = v + 42'sd8192;
		return t[40:14];
	endfunction

	function automatic logic signed [26:0] sat24(input logic signed [27:0] v);
		if (v > 28'sd8388607) return 27'sd8388607;
		if (v < -28'sd8388608) return -27'sd8388608;
		return v[26:0];
	endfunction

endpackage

[src/tfs_isqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module tfs_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [51:0] radicand,
	output logic        done,
	output logic [25:0] root
);
	logic [51:0] rem_q;
	logic [51:0] res_q;
	logic [51:0] bit_q;
	logic        busy_q;
	logic [51:0] trial;

	assign trial = res_q + bit_q;
	assign root = res_q[25:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q[1:0] != 2'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 52'd1 << 50;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

[src/terrain_foothold_selector.sv]
// Top level of the terrain foothold selector.
// A load or ignored item goes straight to the done state, which raises out_valid once the
// output is free. A query checks the footprint, then reads, rotates and checks each used slot;
// a candidate also goes through back-rotation, world point, distance, square root and compare.
// With no candidate it walks the slots again for terrain height. One item is in work at once.
// Reset clears configuration, the footprint and control; tread memory is undefined.
module terrain_foothold_selector #(
	parameter int TREAD_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [3:0]         slot,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [22:0]        half_x,
	input  logic [22:0]        half_y,
	input  logic signed [15:0] cos_yaw,
	input  logic signed [15:0] sin_yaw,
	input  logic signed [23:0] height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] foot_x,
	output logic signed [23:0] foot_y,
	output logic signed [23:0] foot_z,
	output logic               fallback
);
	import tfs_pkg::*;

	localparam int IW = (TREAD_SLOTS > 1) ? $clog2(TREAD_SLOTS) : 1;
	localparam int CW = $clog2(TREAD_SLOTS + 1);

	// configuration
	logic signed [23:0] ground_q;
	logic [22:0]        max_step_q, margin_x_q, margin_y_q;
	logic [4:0]         region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q <= '0;
			max_step_q <= 23'd819;
			margin_x_q <= 23'd410;
			margin_y_q <= 23'd205;
			region_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GROUND: ground_q <= cfg_data;
				CFG_MAX_STEP: max_step_q <= cfg_data[22:0];
				CFG_MARGIN_X: margin_x_q <= cfg_data[22:0];
				CFG_MARGIN_Y: margin_y_q <= cfg_data[22:0];
				CFG_REGION_COUNT: region_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// slot count in use, capped at the table depth
	logic [CW-1:0] used;
	always_comb begin
		if ({27'd0, region_q} > TREAD_SLOTS) used = CW'(TREAD_SLOTS);
		else used = CW'(region_q);
	end

	// tread memory: one write port for loads, one registered read
	tread_t mem [TREAD_SLOTS];
	tread_t rd_q;
	logic [IW-1:0] idx_q;
	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_xfer && mode == MODE_TREAD && {28'd0, slot} < TREAD_SLOTS)
			mem[IW'(slot)] <= '{cx: pos_x, cy: pos_y, hx: half_x, hy: half_y,
				c: cos_yaw, s: sin_yaw, h: height};
		rd_q <= mem[idx_q];
	end

	// footprint
	logic signed [23:0] fp_cx_q, fp_cy_q;
	logic [22:0]        fp_hx_q, fp_hy_q;
	logic signed [15:0] fp_c_q, fp_s_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_cx_q <= '0; fp_cy_q <= '0; fp_hx_q <= '0; fp_hy_q <= '0;
			fp_c_q <= 16'sd16384; fp_s_q <= '0;
		end else if (in_xfer && mode == MODE_FOOTPRINT) begin
			fp_cx_q <= pos_x; fp_cy_q <= pos_y; fp_hx_q <= half_x; fp_hy_q <= half_y;
			fp_c_q <= cos_yaw; fp_s_q <= sin_yaw;
		end
	end

	// query registers
	state_t state_q, state_d;
	logic signed [23:0] px_q, py_q, ph_q;
	logic [CW-1:0] cnt_q;
	logic have_q;
	logic signed [26:0] best_q;
	logic signed [23:0] rx_q, ry_q, rz_q, hmax_q;
	logic signed [41:0] m1_q, m2_q, m3_q, m4_q;
	logic signed [26:0] lx_q, ly_q;
	logic signed [23:0] wx_q, wy_q;
	logic signed [26:0] bonus_q;
	logic px_is_query_q;
	// fb_pass_q is set while walking the slots again for terrain height
	logic fb_pass_q;
	logic sq_start, sq_done;
	logic [25:0] sq_root;
	logic [51:0] sq_in;

	tfs_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root)
	);

	// shared rotation products selected by phase
	logic signed [24:0] dx, dy;
	logic signed [15:0] rc, rs;
	always_comb begin
		if (state_q == ST_FP_ROT) begin
			dx = 25'(px_q) - 25'(fp_cx_q);
			dy = 25'(py_q) - 25'(fp_cy_q);
			rc = fp_c_q; rs = fp_s_q;
		end else begin
			dx = 25'(px_q) - 25'(rd_q.cx);
			dy = 25'(py_q) - 25'(rd_q.cy);
			rc = rd_q.c; rs = rd_q.s;
		end
	end

	logic signed [26:0] lx, ly, clx, cly, ux, uy, ax, ay, dh, hxs, hys;
	always_comb begin
		lx = rq14(m1_q + m2_q);
		ly = rq14(m4_q - m3_q);
		ax = (lx < 0) ? -lx : lx;
		ay = (ly < 0) ? -ly : ly;
		ux = 27'(rd_q.hx) - 27'(margin_x_q);
		uy = 27'(rd_q.hy) - 27'(margin_y_q);
		clx = lx; cly = ly;
		if (clx > ux) clx = ux;
		if (clx < -ux) clx = -ux;
		if (cly > uy) cly = uy;
		if (cly < -uy) cly = -uy;
		dh = 27'(rd_q.h) - 27'(ph_q);
		if (dh < 0) dh = -dh;
		hxs = 27'(rd_q.hx) + 27'(CONTAIN_SLACK);
		hys = 27'(rd_q.hy) + 27'(CONTAIN_SLACK);
	end

	logic signed [26:0] gdh;
	logic signed [26:0] wxf, wyf, score;
	logic signed [24:0] ddx, ddy;
	logic signed [49:0] sq_x, sq_y;
	always_comb begin
		gdh = 27'(ground_q) - 27'(ph_q);
		if (gdh < 0) gdh = -gdh;
		wxf = sat24(28'(rd_q.cx) + 28'(rq14(m1_q - m2_q)));
		wyf = sat24(28'(rd_q.cy) + 28'(rq14(m3_q + m4_q)));
		// squared distance from the registered world point
		ddx = 25'(wx_q) - 25'(px_q);
		ddy = 25'(wy_q) - 25'(py_q);
		sq_x = 50'(ddx) * 50'(ddx);
		sq_y = 50'(ddy) * 50'(ddy);
		sq_in = 52'(sq_x) + 52'(sq_y);
		score = $signed({1'b0, sq_root}) - bonus_q;
	end

	// decisions of the current step
	logic last, tread_ok, cand, ground_ok, need_fb, out_free, better;
	assign last = (cnt_q + CW'(1) >= used);
	// tread usable after margin shrink
	assign tread_ok = (ux >= 0) && (uy >= 0);
	assign cand = tread_ok && ax <= hxs && ay <= hys && dh <= 27'(max_step_q);
	assign ground_ok = !((fp_hx_q != '0) && ax <= 27'(fp_hx_q) && ay <= 27'(fp_hy_q))
		&& gdh <= 27'(max_step_q);
	assign need_fb = px_is_query_q && !have_q && !fb_pass_q && (used != '0);
	assign out_free = !out_valid || !out_stall;
	assign better = !have_q || score < best_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = (mode == MODE_QUERY) ? ST_FP_ROT : ST_DONE;
			ST_FP_ROT: state_d = ST_FP_CHK;
			ST_FP_CHK: state_d = (used == '0) ? ST_DONE : ST_RD;
			ST_RD: state_d = fb_pass_q ? ST_FB_ROT : ST_ROT;
			ST_ROT: state_d = ST_LOC;
			ST_LOC: state_d = cand ? ST_BACK : (last ? ST_DONE : ST_RD);
			ST_BACK: state_d = ST_WORLD;
			ST_WORLD: state_d = ST_DIST;
			ST_DIST: state_d = ST_SQRT;
			ST_SQRT: if (sq_done) state_d = ST_CMP;
			ST_CMP: state_d = last ? ST_DONE : ST_RD;
			ST_FB_ROT: state_d = ST_FB_CHK;
			ST_FB_CHK: state_d = last ? ST_DONE : ST_RD;
			ST_DONE: begin
				// no candidate: walk the slots again for terrain height
				if (need_fb) state_d = ST_RD;
				else if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	logic out_load, rewind, advance;
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		sq_start = (state_q == ST_DIST);
		out_load = (state_q == ST_DONE) && !need_fb && out_free;
		rewind = (state_q == ST_DONE) && need_fb;
		advance = !last && ((state_q == ST_LOC && !cand) || state_q == ST_CMP
			|| state_q == ST_FB_CHK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			fb_pass_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			have_q <= 1'b0;
			px_is_query_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the result until it is taken
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (in_xfer) begin
				cnt_q <= '0; idx_q <= '0; fb_pass_q <= 1'b0;
				px_is_query_q <= (mode == MODE_QUERY);
			end else if (rewind) begin
				fb_pass_q <= 1'b1; cnt_q <= '0; idx_q <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + CW'(1);
				idx_q <= IW'(cnt_q + CW'(1));
			end
			if (in_xfer) have_q <= 1'b0;
			else if ((state_q == ST_FP_CHK && ground_ok) || (state_q == ST_CMP && better))
				have_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_q <= pos_x; py_q <= pos_y; ph_q <= height;
			hmax_q <= ground_q;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			best_q <= '0;
		end
		case (state_q)
			ST_FP_ROT, ST_ROT, ST_FB_ROT: begin
				m1_q <= 42'(rc) * 42'(dx); m2_q <= 42'(rs) * 42'(dy);
				m3_q <= 42'(rs) * 42'(dx); m4_q <= 42'(rc) * 42'(dy);
			end
			ST_FP_CHK: if (ground_ok) begin
				rx_q <= px_q; ry_q <= py_q; rz_q <= ground_q; best_q <= '0;
			end
			ST_LOC: begin
				lx_q <= clx; ly_q <= cly;
			end
			ST_BACK: begin
				m1_q <= 42'(rd_q.c) * 42'(lx_q); m2_q <= 42'(rd_q.s) * 42'(ly_q);
				m3_q <= 42'(rd_q.s) * 42'(lx_q); m4_q <= 42'(rd_q.c) * 42'(ly_q);
			end
			ST_WORLD: begin
				wx_q <= wxf[23:0]; wy_q <= wyf[23:0];
				bonus_q <= (27'(rd_q.h) > 27'(ph_q) + 27'(STEP_EPS)) ? 27'(STEP_BONUS) : '0;
			end
			ST_CMP: if (better) begin
				best_q <= score; rx_q <= wx_q; ry_q <= wy_q; rz_q <= rd_q.h;
			end
			ST_FB_CHK: if (ax <= 27'(rd_q.hx) && ay <= 27'(rd_q.hy) && rd_q.h > hmax_q)
				hmax_q <= rd_q.h;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (px_is_query_q && !have_q) begin
				foot_x <= px_q; foot_y <= py_q; foot_z <= hmax_q; fallback <= 1'b1;
			end else begin
				foot_x <= rx_q; foot_y <= ry_q; foot_z <= rz_q; fallback <= 1'b0;
			end
		end
	end
endmodule
